@@ rtl/bnf_grammar_tokenizer_assert.svh @@
// assertion macros for the grammar tokenizer checker
// no dependencies; taken in by the checker file
`ifndef BNF_GRAMMAR_TOKENIZER_ASSERT_SVH
`define BNF_GRAMMAR_TOKENIZER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BGT_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// next-cycle implication, disabled during reset
`define BGT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

@@ rtl/bgt_pkg.sv @@
// shared types and constants for the grammar tokenizer
// no dependencies
`default_nettype none

package bgt_pkg;

  // fixed widths of the token fields
  localparam int TOKEN_POS_W  = 20;
  localparam int TOKEN_LINE_W = 16;
  localparam int KIND_W       = 4;

  // tokens one byte can cause, and the queue between front and back
  localparam int MAX_TOKENS = 4;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W      = $clog2(MAX_TOKENS);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_IDENT   = 4'd0,
    KIND_TERM    = 4'd1,
    KIND_LIT     = 4'd2,
    KIND_COLEQ   = 4'd3,
    KIND_SEMI    = 4'd4,
    KIND_BAR     = 4'd5,
    KIND_LPAREN  = 4'd6,
    KIND_RPAREN  = 4'd7,
    KIND_STAR    = 4'd8,
    KIND_PLUS    = 4'd9,
    KIND_QMARK   = 4'd10,
    KIND_EOF     = 4'd11,
    KIND_INVALID = 4'd12
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_LITERAL = 3'd3,
    MODE_COLON1  = 3'd4,
    MODE_COLON2  = 3'd5
  } mode_t;

  typedef struct packed {
    kind_t                   kind;
    logic [TOKEN_POS_W-1:0]  start;
    logic [TOKEN_POS_W-1:0]  length;
    logic [TOKEN_LINE_W-1:0] line;
  } token_t;

  // all tokens caused by one byte
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [CNT_W-1:0]        count;
  } bundle_t;

  // queue status seen by front and back
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/bgt_byte_if.sv @@
// input channel: one byte of grammar text per word
// no dependencies
`default_nettype none

interface bgt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/bgt_token_if.sv @@
// output channel: one token per word
// depends on bgt_pkg for field widths
`default_nettype none

interface bgt_token_if;
  logic                             valid;
  logic                             ready;
  logic [bgt_pkg::KIND_W-1:0]       token_kind;
  logic [bgt_pkg::TOKEN_POS_W-1:0]  token_start;
  logic [bgt_pkg::TOKEN_POS_W-1:0]  token_length;
  logic [bgt_pkg::TOKEN_LINE_W-1:0] token_line;
  logic                             run_end;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output token_line, output run_end,
                  input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input token_line, input run_end,
                output ready);
endinterface

`default_nettype wire

@@ rtl/bgt_front.sv @@
// scanner front: classifies each byte and builds the tokens it closes
// depends on bgt_pkg
`default_nettype none

module bgt_front #(
  parameter int POSITION_BITS = 20,
  parameter int LINE_BITS     = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       text_byte,
  input  wire logic             final_byte,
  input  wire bgt_pkg::q_stat_t q_stat,
  output logic                  push,
  output bgt_pkg::bundle_t      push_data
);

  localparam int PB  = POSITION_BITS;
  localparam int LB  = LINE_BITS;
  localparam int TPW = bgt_pkg::TOKEN_POS_W;
  localparam int TLW = bgt_pkg::TOKEN_LINE_W;
  localparam int CW  = bgt_pkg::CNT_W;
  localparam int IW  = bgt_pkg::IDX_W;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  // scanner state
  bgt_pkg::mode_t  mode, mode_next;
  logic [PB-1:0]   pos, pos_next;
  logic [LB-1:0]   line_cnt, line_cnt_next;
  logic [PB-1:0]   pstart, pstart_next;
  logic [LB-1:0]   pline, pline_next;
  logic            seen_letter, seen_letter_next;
  logic            all_upper, all_upper_next;
  logic [7:0]      prev_char, prev_char_next;

  logic            accept;
  logic            c_upper, c_lower, c_digit, c_alpha, c_space;
  logic            do_start;
  logic [PB-1:0]   pos_inc;
  logic [PB-1:0]   second;
  bgt_pkg::bundle_t b;

  function automatic logic [PB-1:0] inc_sat(logic [PB-1:0] v);
    return (v == {PB{1'b1}}) ? v : v + PB'(1);
  endfunction

  function automatic logic [PB-1:0] span(logic [PB-1:0] s, logic [PB-1:0] e);
    return (e >= s) ? e - s : '0;
  endfunction

  function automatic bgt_pkg::token_t mk(bgt_pkg::kind_t k, logic [PB-1:0] s,
                                         logic [PB-1:0] len, logic [LB-1:0] ln);
    bgt_pkg::token_t t;
    t.kind   = k;
    t.start  = TPW'(s);
    t.length = TPW'(len);
    t.line   = TLW'(ln);
    return t;
  endfunction

  function automatic bgt_pkg::bundle_t add(bgt_pkg::bundle_t bi, bgt_pkg::token_t t);
    bgt_pkg::bundle_t r;
    r = bi;
    if (bi.count < CW'(bgt_pkg::MAX_TOKENS)) begin
      r.tok[bi.count[IW-1:0]] = t;
      r.count = bi.count + CW'(1);
    end
    return r;
  endfunction

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // character classes
  assign c_upper = (text_byte >= 8'h41) && (text_byte <= 8'h5A);
  assign c_lower = (text_byte >= 8'h61) && (text_byte <= 8'h7A);
  assign c_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
  assign c_alpha = c_upper || c_lower;
  assign c_space = (text_byte == CH_SPACE) || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));

  assign pos_inc = inc_sat(pos);
  assign second  = inc_sat(pstart);

  // next state and the tokens this byte causes
  always_comb begin
    mode_next        = mode;
    pstart_next      = pstart;
    pline_next       = pline;
    seen_letter_next = seen_letter;
    all_upper_next   = all_upper;
    prev_char_next   = prev_char;
    do_start         = 1'b0;
    b                = '0;

    case (mode)
      bgt_pkg::MODE_COMMENT: begin
        if (text_byte == CH_NL) mode_next = bgt_pkg::MODE_IDLE;
      end
      bgt_pkg::MODE_IDENT: begin
        if (c_alpha || c_digit || text_byte == CH_USCORE) begin
          if (c_alpha) seen_letter_next = 1'b1;
          if (c_lower) all_upper_next = 1'b0;
        end else begin
          b = add(b, mk((seen_letter && all_upper) ? bgt_pkg::KIND_TERM
                                                   : bgt_pkg::KIND_IDENT,
                        pstart, span(pstart, pos), pline));
          do_start = 1'b1;
        end
      end
      bgt_pkg::MODE_LITERAL: begin
        if (text_byte == CH_QUOTE && prev_char != CH_BSLASH) begin
          b = add(b, mk(bgt_pkg::KIND_LIT, pstart, span(pstart, pos_inc), pline));
          mode_next = bgt_pkg::MODE_IDLE;
        end else begin
          prev_char_next = text_byte;
        end
      end
      bgt_pkg::MODE_COLON1: begin
        if (text_byte == CH_COLON) begin
          mode_next = bgt_pkg::MODE_COLON2;
        end else begin
          b = add(b, mk(bgt_pkg::KIND_INVALID, pstart, PB'(1), pline));
          do_start = 1'b1;
        end
      end
      bgt_pkg::MODE_COLON2: begin
        if (text_byte == CH_EQ) begin
          b = add(b, mk(bgt_pkg::KIND_COLEQ, pstart, PB'(3), pline));
          mode_next = bgt_pkg::MODE_IDLE;
        end else if (text_byte == CH_COLON) begin
          b = add(b, mk(bgt_pkg::KIND_INVALID, pstart, PB'(1), pline));
          pstart_next = second;
        end else begin
          b = add(b, mk(bgt_pkg::KIND_INVALID, pstart, PB'(1), pline));
          b = add(b, mk(bgt_pkg::KIND_INVALID, second, PB'(1), pline));
          do_start = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // a byte seen outside any open token
    if (do_start) begin
      mode_next = bgt_pkg::MODE_IDLE;
      if (!c_space) begin
        case (text_byte)
          CH_HASH:   mode_next = bgt_pkg::MODE_COMMENT;
          CH_COLON: begin
            mode_next   = bgt_pkg::MODE_COLON1;
            pstart_next = pos;
            pline_next  = line_cnt;
          end
          CH_QUOTE: begin
            mode_next      = bgt_pkg::MODE_LITERAL;
            pstart_next    = pos;
            pline_next     = line_cnt;
            prev_char_next = 8'h00;
          end
          CH_SEMI:   b = add(b, mk(bgt_pkg::KIND_SEMI, pos, PB'(1), line_cnt));
          CH_BAR:    b = add(b, mk(bgt_pkg::KIND_BAR, pos, PB'(1), line_cnt));
          CH_LPAREN: b = add(b, mk(bgt_pkg::KIND_LPAREN, pos, PB'(1), line_cnt));
          CH_RPAREN: b = add(b, mk(bgt_pkg::KIND_RPAREN, pos, PB'(1), line_cnt));
          CH_STAR:   b = add(b, mk(bgt_pkg::KIND_STAR, pos, PB'(1), line_cnt));
          CH_PLUS:   b = add(b, mk(bgt_pkg::KIND_PLUS, pos, PB'(1), line_cnt));
          CH_QMARK:  b = add(b, mk(bgt_pkg::KIND_QMARK, pos, PB'(1), line_cnt));
          default: begin
            if (c_alpha || text_byte == CH_USCORE) begin
              mode_next        = bgt_pkg::MODE_IDENT;
              pstart_next      = pos;
              pline_next       = line_cnt;
              seen_letter_next = c_alpha;
              all_upper_next   = !c_lower;
            end else begin
              b = add(b, mk(bgt_pkg::KIND_INVALID, pos, PB'(1), line_cnt));
            end
          end
        endcase
      end
    end

    // counters, saturating
    pos_next = pos_inc;
    if (text_byte == CH_NL && line_cnt != {LB{1'b1}}) begin
      line_cnt_next = line_cnt + LB'(1);
    end else begin
      line_cnt_next = line_cnt;
    end

    // last byte: close what is open, add end of file, back to reset
    if (final_byte) begin
      case (mode_next)
        bgt_pkg::MODE_IDENT:
          b = add(b, mk((seen_letter_next && all_upper_next) ? bgt_pkg::KIND_TERM
                                                             : bgt_pkg::KIND_IDENT,
                        pstart_next, span(pstart_next, pos_next), pline_next));
        bgt_pkg::MODE_LITERAL:
          b = add(b, mk(bgt_pkg::KIND_LIT, pstart_next,
                        span(pstart_next, pos_next), pline_next));
        bgt_pkg::MODE_COLON1:
          b = add(b, mk(bgt_pkg::KIND_INVALID, pstart_next, PB'(1), pline_next));
        bgt_pkg::MODE_COLON2: begin
          b = add(b, mk(bgt_pkg::KIND_INVALID, pstart_next, PB'(1), pline_next));
          b = add(b, mk(bgt_pkg::KIND_INVALID, inc_sat(pstart_next), PB'(1),
                        pline_next));
        end
        default: ;
      endcase
      b = add(b, mk(bgt_pkg::KIND_EOF, pos_next, '0, line_cnt_next));
      mode_next        = bgt_pkg::MODE_IDLE;
      pos_next         = '0;
      line_cnt_next    = LB'(1);
      pstart_next      = '0;
      pline_next       = LB'(1);
      seen_letter_next = 1'b0;
      all_upper_next   = 1'b1;
      prev_char_next   = 8'h00;
    end
  end

  assign push      = accept && (b.count != '0);
  assign push_data = b;

  // scanner state register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= bgt_pkg::MODE_IDLE;
      pos         <= '0;
      line_cnt    <= LB'(1);
      pstart      <= '0;
      pline       <= LB'(1);
      seen_letter <= 1'b0;
      all_upper   <= 1'b1;
      prev_char   <= 8'h00;
    end else if (accept) begin
      mode        <= mode_next;
      pos         <= pos_next;
      line_cnt    <= line_cnt_next;
      pstart      <= pstart_next;
      pline       <= pline_next;
      seen_letter <= seen_letter_next;
      all_upper   <= all_upper_next;
      prev_char   <= prev_char_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bgt_queue.sv @@
// short queue of token bundles between scanner and output
// depends on bgt_pkg
`default_nettype none

module bgt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bgt_pkg::bundle_t push_data,
  input  wire logic             pop,
  output bgt_pkg::bundle_t      head,
  output bgt_pkg::q_stat_t      stat
);

  localparam int DEPTH = bgt_pkg::Q_DEPTH;
  localparam int PW    = bgt_pkg::Q_PTR_W;
  localparam int CW    = bgt_pkg::Q_CNT_W;

  bgt_pkg::bundle_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign stat.not_empty = (count != '0);
  assign stat.full      = (count == CW'(DEPTH));
  assign head           = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bgt_back.sv @@
// output back end: sends the tokens of each bundle one word at a time
// depends on bgt_pkg
`default_nettype none

module bgt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bgt_pkg::bundle_t head,
  input  wire bgt_pkg::q_stat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bgt_pkg::token_t       out_tok,
  output logic                  run_end
);

  localparam int IW = bgt_pkg::IDX_W;
  localparam int CW = bgt_pkg::CNT_W;

  logic [IW-1:0] idx;
  logic          last;

  // current token of the head bundle
  assign out_valid = q_stat.not_empty;
  assign out_tok   = head.tok[idx];
  assign last      = ({1'b0, idx} == CW'(head.count - CW'(1)));
  assign run_end   = last;
  assign pop       = out_valid && out_ready && last;

  // token index within the bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= last ? '0 : idx + IW'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/bnf_grammar_tokenizer.sv @@
// top level of the grammar tokenizer: scanner, bundle queue and output stage
// depends on bgt_pkg, bgt_byte_if, bgt_token_if, bgt_front, bgt_queue, bgt_back
`default_nettype none

// Takes grammar text one byte per word and returns one token per word. The
// scanner takes a byte every cycle as long as its two-entry bundle queue is
// not full, and the tokens a byte closes are registered in that queue before
// they reach the output. The output stage sends one token per word, so it
// sets the sustained rate: one byte per cycle while bytes close at most one
// token and the output is ready, and a byte that closes several (up to four,
// e.g. the last byte with an open token and the end-of-file token) holds the
// input once the queue is full. run_end marks the last token caused by a
// byte. No clearing pass follows reset; the block is ready once rst falls.
module bnf_grammar_tokenizer #(
  parameter int POSITION_BITS = 20,
  parameter int LINE_BITS     = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  bgt_byte_if.sink     text_in,
  bgt_token_if.source  token_out
);

  bgt_pkg::q_stat_t q_stat;
  bgt_pkg::bundle_t push_data;
  bgt_pkg::bundle_t head;
  bgt_pkg::token_t  out_tok;
  logic             push;
  logic             pop;
  logic             in_ready;
  logic             out_valid;
  logic             run_end;

  // scanner
  bgt_front #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text_in.valid),
    .in_ready  (in_ready),
    .text_byte (text_in.text_byte),
    .final_byte(text_in.final_byte),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // bundle queue
  bgt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // output stage
  bgt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(token_out.ready),
    .out_tok  (out_tok),
    .run_end  (run_end)
  );

  assign text_in.ready          = in_ready;
  assign token_out.valid        = out_valid;
  assign token_out.token_kind   = out_tok.kind;
  assign token_out.token_start  = out_tok.start;
  assign token_out.token_length = out_tok.length;
  assign token_out.token_line   = out_tok.line;
  assign token_out.run_end      = run_end;

endmodule

`default_nettype wire

@@ rtl/bgt_checker.sv @@
// port-level checks on the grammar tokenizer, bound to the top level
// depends on bgt_pkg and bnf_grammar_tokenizer_assert.svh
`default_nettype none

`include "bnf_grammar_tokenizer_assert.svh"

module bgt_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [bgt_pkg::KIND_W-1:0]       token_kind,
  input wire logic [bgt_pkg::TOKEN_POS_W-1:0]  token_start,
  input wire logic [bgt_pkg::TOKEN_POS_W-1:0]  token_length,
  input wire logic [bgt_pkg::TOKEN_LINE_W-1:0] token_line,
  input wire logic                             run_end
);

  // a stalled word keeps its token
  `BGT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_start) && $stable(token_length) && $stable(token_line) && $stable(run_end))

  // end of file is empty and closes its run
  `BGT_ASSERT_NOW(a_eof_shape, clk, rst, out_valid && token_kind == bgt_pkg::KIND_EOF, token_length == '0 && run_end)

  // lines count from one, kinds stay in range
  `BGT_ASSERT_NOW(a_line_kind, clk, rst, out_valid, token_line != '0 && token_kind <= bgt_pkg::KIND_INVALID)

  // rule operator is three bytes
  `BGT_ASSERT_NOW(a_coleq_len, clk, rst, out_valid && token_kind == bgt_pkg::KIND_COLEQ, token_length == bgt_pkg::TOKEN_POS_W'(3))

  // stray bytes, semicolons and bars are one byte
  `BGT_ASSERT_NOW(a_single_len, clk, rst, out_valid && (token_kind == bgt_pkg::KIND_INVALID || token_kind == bgt_pkg::KIND_SEMI || token_kind == bgt_pkg::KIND_BAR), token_length == bgt_pkg::TOKEN_POS_W'(1))

endmodule

bind bnf_grammar_tokenizer bgt_checker u_bgt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (token_out.valid),
  .out_ready   (token_out.ready),
  .token_kind  (token_out.token_kind),
  .token_start (token_out.token_start),
  .token_length(token_out.token_length),
  .token_line  (token_out.token_line),
  .run_end     (token_out.run_end)
);

`default_nettype wire
